// ===== design/b32e_pkg.sv =====
// Shared types, constants and the symbol-to-letter mapping for the base32 encoder.
package b32e_pkg;

  // Most characters one input byte can cause (final byte at the first or second position of a group).
  localparam int unsigned MAX_CHARS = 5;

  // Default depth of the job queue between front and back.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // ASCII code of the padding character.
  localparam logic [6:0] PAD_CHAR = 7'h2A;

  // One character slot: either a 5-bit symbol or a pad.
  typedef struct packed {
    logic       pad;
    logic [4:0] val;
  } sym_t;

  // Everything the back end needs to emit the characters of one byte.
  typedef struct packed {
    sym_t [MAX_CHARS-1:0] syms;
    logic [2:0]           last_idx;
  } job_t;

  localparam sym_t PAD_SYM = '{pad: 1'b1, val: 5'd0};

  // Map a 5-bit symbol onto the alphabet ABCDEFGHJKLMNPQRSTUVWXYZ23456789.
  function automatic logic [6:0] sym_to_ascii(input logic [4:0] v);
    logic [6:0] r;
    case (v) inside
      [5'd0:5'd7]:   r = 7'h41 + {2'b00, v};  // A..H
      [5'd8:5'd12]:  r = 7'h42 + {2'b00, v};  // J..N
      [5'd13:5'd23]: r = 7'h43 + {2'b00, v};  // P..Z
      default:       r = 7'h1A + {2'b00, v};  // 2..9
    endcase
    return r;
  endfunction

endpackage

// ===== design/b32e_front.sv =====
// Front end: accepts bytes, tracks group position and carry, builds character jobs.
module b32e_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_final_byte,
  input  logic             q_full,
  output logic             push,
  output b32e_pkg::job_t   job
);

  typedef enum logic [2:0] {
    POS0 = 3'd0,
    POS1 = 3'd1,
    POS2 = 3'd2,
    POS3 = 3'd3,
    POS4 = 3'd4
  } pos_t;

  pos_t       pos_r, pos_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic [7:0] b;
  logic       fin;

  assign b        = in_data_byte;
  assign fin      = in_final_byte;
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Split the byte into symbols for the current group position.
  always_comb begin
    job       = '0;
    pos_nxt   = pos_r;
    carry_nxt = carry_r;
    case (pos_r)
      POS1: begin
        job.syms[0]  = {1'b0, carry_r[2:0], b[7:6]};
        job.syms[1]  = {1'b0, b[5:1]};
        job.last_idx = 3'd1;
        carry_nxt    = {3'b000, b[0]};
        pos_nxt      = POS2;
        if (fin) begin
          job.syms[2]  = {1'b0, b[0], 4'b0000};
          job.syms[3]  = b32e_pkg::PAD_SYM;
          job.syms[4]  = b32e_pkg::PAD_SYM;
          job.last_idx = 3'd4;
        end
      end
      POS2: begin
        job.syms[0]  = {1'b0, carry_r[0], b[7:4]};
        job.last_idx = 3'd0;
        carry_nxt    = b[3:0];
        pos_nxt      = POS3;
        if (fin) begin
          job.syms[1]  = {1'b0, b[3:0], 1'b0};
          job.syms[2]  = {1'b0, 5'd0};
          job.syms[3]  = b32e_pkg::PAD_SYM;
          job.last_idx = 3'd3;
        end
      end
      POS3: begin
        job.syms[0]  = {1'b0, carry_r, b[7]};
        job.syms[1]  = {1'b0, b[6:2]};
        job.last_idx = 3'd1;
        carry_nxt    = {2'b00, b[1:0]};
        pos_nxt      = POS4;
        if (fin) begin
          job.syms[2]  = {1'b0, b[1:0], 3'b000};
          job.syms[3]  = {1'b0, 5'd0};
          job.last_idx = 3'd3;
        end
      end
      POS4: begin
        job.syms[0]  = {1'b0, carry_r[1:0], b[7:5]};
        job.syms[1]  = {1'b0, b[4:0]};
        job.last_idx = 3'd1;
        carry_nxt    = 4'd0;
        pos_nxt      = POS0;
      end
      default: begin
        // Start of a group (unused codes fall here too).
        job.syms[0]  = {1'b0, b[7:3]};
        job.last_idx = 3'd0;
        carry_nxt    = {1'b0, b[2:0]};
        pos_nxt      = POS1;
        if (fin) begin
          job.syms[1]  = {1'b0, b[2:0], 2'b00};
          job.syms[2]  = b32e_pkg::PAD_SYM;
          job.syms[3]  = b32e_pkg::PAD_SYM;
          job.syms[4]  = b32e_pkg::PAD_SYM;
          job.last_idx = 3'd4;
        end
      end
    endcase
    // Drop back to a fresh group after the end of a message.
    if (fin) begin
      pos_nxt   = POS0;
      carry_nxt = 4'd0;
    end
  end

  // Hold position and carry; advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS0;
      carry_r <= 4'd0;
    end else if (push) begin
      pos_r   <= pos_nxt;
      carry_r <= carry_nxt;
    end
  end

endmodule

// ===== design/b32e_queue.sv =====
// Small job queue that decouples the front end from the character serializer.
module b32e_queue #(
  parameter int unsigned DEPTH = b32e_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b32e_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output b32e_pkg::job_t head_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  b32e_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_job   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Write the incoming job.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/b32e_back.sv =====
// Back end: walks a job into the output register, one character per cycle while out_ready allows.
module b32e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  b32e_pkg::job_t head_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     out_char,
  output logic           out_last
);

  logic [2:0]     idx_r, idx_nxt;
  logic           out_valid_r;
  logic [6:0]     out_char_r, out_char_nxt;
  logic           out_last_r, out_last_nxt;
  logic           advance, emit, is_last;
  b32e_pkg::sym_t cur;

  assign advance = !out_valid_r || out_ready;
  assign emit    = advance && head_valid;
  assign cur     = head_job.syms[idx_r];
  assign is_last = (idx_r == head_job.last_idx);
  assign pop     = emit && is_last;

  // Pick the character for the current slot.
  always_comb begin
    out_char_nxt = cur.pad ? b32e_pkg::PAD_CHAR : b32e_pkg::sym_to_ascii(cur.val);
    out_last_nxt = is_last;
    idx_nxt      = is_last ? 3'd0 : idx_r + 3'd1;
  end

  // Hold the output beat until taken; load the next one when free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else if (advance) begin
      out_valid_r <= head_valid;
      if (emit) begin
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

// ===== design/base32_byte_to_char_encoder.sv =====
// The first character of a byte passes through the job queue and then the output register.
// Throughput: one character per cycle while out_ready is high, set by the single
//   character output register; a byte gives 1 or 2 characters (up to 5 when it ends
//   a message), and new bytes are taken while earlier ones drain until the queue fills.
// Reset (rst_n, synchronous, active low) clears group position, carry, queue and
//   output valid.
module base32_byte_to_char_encoder #(
  parameter int unsigned QUEUE_DEPTH = b32e_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_last
);

  logic           q_full, q_push, q_pop, q_valid;
  b32e_pkg::job_t push_job, head_job;

  b32e_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .q_full        (q_full),
    .push          (q_push),
    .job           (push_job)
  );

  b32e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  b32e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_job   (head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .out_last   (out_last)
  );

`ifndef SYNTHESIS
  // A job is only retired when one is present.
  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job popped from empty queue");

  // Queued jobs never point past the last character slot.
  a_last_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> (head_job.last_idx <= 3'd4))
    else $error("job last index out of range");

  // Retiring a job puts its final character, flagged last, on the output.
  a_pop_emits_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_last))
    else $error("job retired without a last beat");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the base32 byte-to-character encoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Alphabet: symbol 0 sits in the top byte
  localparam logic [8*32-1:0] ALPHABET = "ABCDEFGHJKLMNPQRSTUVWXYZ23456789";
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } char_beat_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_final_byte;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] out_char;
  logic       out_last;

  // Predictor state: position in the five-byte group and leftover bits
  logic [2:0] grp_pos;
  logic [3:0] carry;

  char_beat_t  expected_chars[$];
  int unsigned n_errors;
  int unsigned bytes_sent;
  int unsigned idle_cycles;
  bit          gap_en;
  bit          stall_en;

  base32_byte_to_char_encoder u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_final_byte(in_final_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [6:0] letter_of(input logic [4:0] v);
    return ALPHABET[8*(31-v) +: 7];
  endfunction

  // Work out the characters one accepted byte causes and queue them
  task automatic predict_chars(input logic [7:0] b, input logic fin);
    logic [6:0] chars[$];
    char_beat_t beat;
    case (grp_pos)
      3'd1: begin
        chars.push_back(letter_of({carry[2:0], b[7:6]}));
        chars.push_back(letter_of(b[5:1]));
        carry = {3'b000, b[0]};
        grp_pos = 3'd2;
        if (fin) begin
          chars.push_back(letter_of({b[0], 4'b0000}));
          chars.push_back(b32e_pkg::PAD_CHAR);
          chars.push_back(b32e_pkg::PAD_CHAR);
        end
      end
      3'd2: begin
        chars.push_back(letter_of({carry[0], b[7:4]}));
        carry = b[3:0];
        grp_pos = 3'd3;
        if (fin) begin
          chars.push_back(letter_of({b[3:0], 1'b0}));
          chars.push_back(letter_of(5'd0));
          chars.push_back(b32e_pkg::PAD_CHAR);
        end
      end
      3'd3: begin
        chars.push_back(letter_of({carry[3:0], b[7]}));
        chars.push_back(letter_of(b[6:2]));
        carry = {2'b00, b[1:0]};
        grp_pos = 3'd4;
        if (fin) begin
          chars.push_back(letter_of({b[1:0], 3'b000}));
          chars.push_back(letter_of(5'd0));
        end
      end
      3'd4: begin
        chars.push_back(letter_of({carry[1:0], b[7:5]}));
        chars.push_back(letter_of(b[4:0]));
        carry = 4'd0;
        grp_pos = 3'd0;
      end
      default: begin
        chars.push_back(letter_of(b[7:3]));
        carry = {1'b0, b[2:0]};
        grp_pos = 3'd1;
        if (fin) begin
          chars.push_back(letter_of({b[2:0], 2'b00}));
          chars.push_back(b32e_pkg::PAD_CHAR);
          chars.push_back(b32e_pkg::PAD_CHAR);
          chars.push_back(b32e_pkg::PAD_CHAR);
        end
      end
    endcase
    if (fin) begin
      grp_pos = 3'd0;
      carry = 4'd0;
    end
    foreach (chars[i]) begin
      beat.ch = chars[i];
      beat.last = (i == chars.size() - 1);
      expected_chars.push_back(beat);
    end
  endtask

  // Mostly no gap, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gap_en || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Present one byte and hold it until the beat is taken
  task automatic send_beat(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_final_byte <= fin;
    do @(posedge clk); while (!in_ready);
    predict_chars(b, fin);
    bytes_sent++;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_beat(pick_byte(), i == len - 1);
    end
  endtask

  // Drop valid and hold off until every queued character has come out
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // Directed: a message ending at each group position, extreme byte values
  task automatic test_final_at_each_position();
    logic [7:0] msg[$];
    msg = {8'hFF};
    foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
    msg = {8'h00, 8'hFF};
    foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
    msg = {8'hFF, 8'h00, 8'hFF};
    foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
    msg = {8'h00, 8'hFF, 8'h00, 8'hFF};
    foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
    msg = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
    // Full group, then a final byte opening the next group
    msg = {8'h00, 8'h44, 8'h32, 8'h14, 8'hC7, 8'hA5};
    foreach (msg[i]) send_beat(msg[i], i == msg.size() - 1);
  endtask

  // No idling on either side: run at full rate
  task automatic test_full_groups_no_idle();
    gap_en = 1'b0;
    stall_en = 1'b0;
    repeat (4) send_message($urandom_range(3, 10));
    gap_en = 1'b1;
    stall_en = 1'b1;
  endtask

  // One message spanning several groups
  task automatic test_long_message();
    send_message(23);
  endtask

  // Sender waits for the output to empty between messages
  task automatic test_drain_between_messages();
    send_message(7);
    hold_until_drained();
    send_message(4);
    hold_until_drained();
  endtask

  // Mostly random messages, some loose bytes with a random end flag
  task automatic test_random_traffic();
    while (bytes_sent < 180) begin
      if ($urandom_range(0, 99) < 85) send_message($urandom_range(1, 12));
      else send_beat(pick_byte(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 99) < 8) hold_until_drained();
    end
  endtask

  // Receiver: bursts of ready, short stalls, an occasional long one
  initial begin : drive_ready
    int unsigned hold;
    int unsigned r;
    bit          level;
    hold = 0;
    level = 1'b1;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_en) begin
        level = 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          level = 1'b1;
          hold = $urandom_range(0, 7);
        end else if (r < 90) begin
          level = 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          level = 1'b0;
          hold = $urandom_range(9, 29);
        end
      end
      out_ready <= level;
    end
  end

  // Compare each character beat with the oldest expectation
  always @(posedge clk) begin : check_chars
    char_beat_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("unexpected char beat: char=%h last=%b", out_char, out_last);
      end else begin
        exp_beat = expected_chars.pop_front();
        if (out_char !== exp_beat.ch || out_last !== exp_beat.last) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("char mismatch: expected char=%h last=%b, got char=%h last=%b",
                     exp_beat.ch, exp_beat.last, out_char, out_last);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_final_byte = 1'b0;
    grp_pos = 3'd0;
    carry = 4'd0;
    n_errors = 0;
    bytes_sent = 0;
    gap_en = 1'b1;
    stall_en = 1'b1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_final_at_each_position();
    test_full_groups_no_idle();
    test_long_message();
    test_drain_between_messages();
    test_random_traffic();

    // Let the last characters out, then allow for the output latency
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && expected_chars.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
